// ===== rtl/lrup_pkg.sv =====
// Shared types and constants for the LRU replacement stack.
package lrup_pkg;

  // Fixed field widths
  localparam int unsigned FcW    = 4;
  localparam int unsigned FaultW = 16;

  // Frame count after reset
  localparam logic [FcW-1:0] FrameCountRst = 4'd8;

  // Saturation value of the fault counter
  localparam logic [FaultW-1:0] FaultMax = '1;

  // Per-cycle command broadcast to every cell of the stack
  typedef struct packed {
    logic upd;  // item accepted: shift/load this cycle
    logic clr;  // invalidate all frames (after the update)
    logic hit;  // referenced page found somewhere in the active frames
  } lrup_cmd_t;

endpackage

// ===== rtl/lrup_cell.sv =====
// One frame of the recency stack: holds a page and its valid bit.
module lrup_cell import lrup_pkg::*; #(
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned NW        = 4,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrup_cmd_t            cmd_i,
  input  logic [NW-1:0]        n_i,
  input  logic [PAGE_BITS-1:0] pg_i,
  input  logic [PAGE_BITS-1:0] nb_page_i,
  input  logic                 nb_valid_i,
  input  logic                 match_i,
  output logic                 match_o,
  output logic [PAGE_BITS-1:0] page_o,
  output logic                 valid_o
);

  localparam logic [NW-1:0] IdxC  = NW'(CELL_IDX);
  localparam logic [NW-1:0] IdxP1 = NW'(CELL_IDX + 1);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid_q, valid_d;
  logic                 active, top, match_here;

  // Position within the active part of the stack
  assign active = (IdxC < n_i);
  assign top    = (n_i == IdxP1);

  // Match and prefix chain: set from the matching frame onward
  assign match_here = active & valid_q & (page_q == pg_i);
  assign match_o    = match_i | match_here;

  // Next frame contents
  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    if (cmd_i.upd) begin
      if (top) begin
        page_d  = pg_i;
        valid_d = 1'b1;
      end else if (active && (!cmd_i.hit || match_o)) begin
        page_d  = nb_page_i;
        valid_d = nb_valid_i;
      end
    end
    if (cmd_i.clr) begin
      valid_d = 1'b0;
    end
  end

  // Valid bit is control state, page is payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign page_o  = page_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement: recency stack built as a row of frame cells.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+-------------------------------
//   in      | in        | in_valid_i / in_stall_o     | page_i, last_reference_i
//   out     | out       | out_valid_o / out_stall_i   | hit_o, evicted_valid_o,
//           |           |                             | evicted_page_o, fault_count_o,
//           |           |                             | sequence_done_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o   | cfg_data_i (frame count)
//
// One item per cycle while the output is not stalled; the result is registered and appears the cycle after accept.
// The critical path is the match compare plus the prefix-match chain through the cells.
// Reset invalidates all frames, clears the fault count and sets the frame count to 8.
// A stalled result holds the output register; a new item is taken in the cycle the
// held result leaves. A frame count write invalidates all frames and keeps the fault count.
module lru_page_replacement import lrup_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [FcW-1:0]       cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 last_reference_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [FaultW-1:0]    fault_count_o,
  output logic                 sequence_done_o
);

  localparam int unsigned NW = $clog2(MAX_FRAMES + 1);

  logic [FcW-1:0]       frame_count_q;
  logic [FaultW-1:0]    fault_q, fault_d;
  logic                 out_valid_q;
  logic                 hit_q, ev_valid_q, done_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic [FaultW-1:0]    fault_cnt_q;

  logic                 accept, cfg_we;
  logic [NW-1:0]        n_eff;
  logic [7:0]           fc8;
  lrup_cmd_t            cmd;
  logic                 hit;
  logic                 ev_valid;
  logic [PAGE_BITS-1:0] ev_page;
  logic [FaultW-1:0]    fault_nxt;

  logic [PAGE_BITS-1:0] page_w  [MAX_FRAMES+1];
  logic                 valid_w [MAX_FRAMES+1];
  logic                 match_w [MAX_FRAMES+1];

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  // Effective frame count: zero acts as one, large values clip to the maximum
  assign fc8 = 8'(frame_count_q);
  always_comb begin
    if (frame_count_q == '0) begin
      n_eff = NW'(1);
    end else if (fc8 > 8'(MAX_FRAMES)) begin
      n_eff = NW'(MAX_FRAMES);
    end else begin
      n_eff = NW'(frame_count_q);
    end
  end

  // Chain ends
  assign page_w[MAX_FRAMES]  = page_i;
  assign valid_w[MAX_FRAMES] = 1'b0;
  assign match_w[0]          = 1'b0;
  assign hit                 = match_w[MAX_FRAMES];

  assign cmd.upd = accept;
  assign cmd.clr = (accept & last_reference_i) | cfg_we;
  assign cmd.hit = hit;

  // Row of frame cells, frame 0 is least recently used
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    lrup_cell #(
      .PAGE_BITS (PAGE_BITS),
      .NW        (NW),
      .CELL_IDX  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .n_i        (n_eff),
      .pg_i       (page_i),
      .nb_page_i  (page_w[i+1]),
      .nb_valid_i (valid_w[i+1]),
      .match_i    (match_w[i]),
      .match_o    (match_w[i+1]),
      .page_o     (page_w[i]),
      .valid_o    (valid_w[i])
    );
  end

  // Eviction and fault counting
  assign ev_valid  = ~hit & valid_w[0];
  assign ev_page   = ev_valid ? page_w[0] : '0;
  assign fault_nxt = (!hit && fault_q != FaultMax) ? fault_q + FaultW'(1) : fault_q;

  always_comb begin
    fault_d = fault_q;
    if (accept) begin
      fault_d = last_reference_i ? '0 : fault_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCountRst;
      fault_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_count_q <= cfg_data_i;
      end
      fault_q <= fault_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q       <= hit;
      ev_valid_q  <= ev_valid;
      ev_page_q   <= ev_page;
      fault_cnt_q <= fault_nxt;
      done_q      <= last_reference_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_cnt_q;
  assign sequence_done_o = done_q;

endmodule

// ===== test/lrup_checker.sv =====
// Recency-stack predictor and result scoreboard for the LRU replacement block.
module lrup_checker import lrup_pkg::*; #(
  parameter int unsigned MAX_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [FcW-1:0]       cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 last_reference_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 hit_i,
  input  logic                 evicted_valid_i,
  input  logic [PAGE_BITS-1:0] evicted_page_i,
  input  logic [FaultW-1:0]    fault_count_i,
  input  logic                 sequence_done_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);

  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FaultW-1:0]    fault_count;
    logic                 sequence_done;
  } page_result_t;

  // Predicted stack: index 0 is least recently used
  logic [PAGE_BITS-1:0] stack_page [MAX_FRAMES];
  logic                 stack_vld  [MAX_FRAMES];
  logic [FaultW-1:0]    fault_total;
  logic [FcW-1:0]       frame_reg;
  page_result_t         expected_q [$];
  int unsigned          error_cnt;

  // Zero frames acts as one, anything above the built size saturates
  function automatic int unsigned active_frames();
    if (frame_reg == '0) return 1;
    if (frame_reg > MAX_FRAMES) return MAX_FRAMES;
    return 32'(frame_reg);
  endfunction

  function automatic void clear_stack();
    int unsigned i;
    for (i = 0; i < MAX_FRAMES; i++) begin
      stack_page[i] = '0;
      stack_vld[i]  = 1'b0;
    end
  endfunction

  // Apply one reference to the stack and return the result it produces
  function automatic page_result_t reference_page(input logic [PAGE_BITS-1:0] pg,
                                                  input logic lst);
    page_result_t res;
    int unsigned  n;
    int unsigned  pos;
    int unsigned  i;
    bit           found;
    res   = '0;
    n     = active_frames();
    pos   = 0;
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && stack_vld[i] && stack_page[i] == pg) begin
        found = 1'b1;
        pos   = i;
      end
    end
    // miss: count the fault and drop the front entry
    if (!found) begin
      if (fault_total != FaultMax) fault_total = fault_total + 1'b1;
      if (stack_vld[0]) begin
        res.evicted_valid = 1'b1;
        res.evicted_page  = stack_page[0];
      end
    end
    // entries behind the hit (or all of them on a miss) move toward the front
    for (i = pos; i + 1 < n; i++) begin
      stack_page[i] = stack_page[i+1];
      stack_vld[i]  = stack_vld[i+1];
    end
    stack_page[n-1] = pg;
    stack_vld[n-1]  = 1'b1;
    res.hit           = found;
    res.fault_count   = fault_total;
    res.sequence_done = lst;
    if (lst) begin
      clear_stack();
      fault_total = '0;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_cnt++;
    end
  endfunction

  // Results are compared before this edge's reference is pushed
  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t exp_r;
    if (!rst_ni) begin
      clear_stack();
      fault_total = '0;
      frame_reg   = FrameCountRst;
      expected_q.delete();
      error_cnt   = 0;
      pending_o  <= 0;
      errors_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual hit %0b ev %0b/%0h cnt %0h done %0b",
                   $time, hit_i, evicted_valid_i, evicted_page_i, fault_count_i,
                   sequence_done_i);
          error_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("hit", 32'(exp_r.hit), 32'(hit_i));
          check_field("evicted_valid", 32'(exp_r.evicted_valid), 32'(evicted_valid_i));
          check_field("evicted_page", 32'(exp_r.evicted_page), 32'(evicted_page_i));
          check_field("fault_count", 32'(exp_r.fault_count), 32'(fault_count_i));
          check_field("sequence_done", 32'(exp_r.sequence_done), 32'(sequence_done_i));
        end
      end
      // frame count write empties the stack, keeps the fault total
      if (cfg_valid_i && cfg_ready_i) begin
        frame_reg = cfg_data_i;
        clear_stack();
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(reference_page(page_i, last_reference_i));
      end
      pending_o <= $unsigned(expected_q.size());
      errors_o  <= error_cnt;
    end
  end

endmodule

// ===== test/tb_lru_page_replacement.sv =====
// Testbench top for the LRU replacement block: clock, reset, stimulus and verdict.
module tb_lru_page_replacement;
  import lrup_pkg::*;

  localparam int unsigned MAX_FRAMES = 8;
  localparam int unsigned PAGE_BITS  = 16;
  localparam int unsigned CHUNKS     = 9;
  localparam int unsigned CHUNK_REFS = 200;
  localparam logic [FcW-1:0] CHUNK_FRAMES [CHUNKS] = '{
    4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd6, 4'd2, 4'd8, 4'd9
  };

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [FcW-1:0]       cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic [PAGE_BITS-1:0] page      = '0;
  logic                 last_ref  = 1'b0;
  logic                 out_stall = 1'b0;

  logic                 cfg_ready_o;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 hit_o;
  logic                 evicted_valid_o;
  logic [PAGE_BITS-1:0] evicted_page_o;
  logic [FaultW-1:0]    fault_count_o;
  logic                 sequence_done_o;

  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          pending;
  int unsigned          errors;
  logic [FcW-1:0]       frames_set     = FrameCountRst;

  always #6 clk_i = ~clk_i;

  lru_page_replacement #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .page_i          (page),
    .last_reference_i(last_ref),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o),
    .sequence_done_o (sequence_done_o)
  );

  lrup_checker #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall_o),
    .page_i          (page),
    .last_reference_i(last_ref),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall),
    .hit_i           (hit_o),
    .evicted_valid_i (evicted_valid_o),
    .evicted_page_i  (evicted_page_o),
    .fault_count_i   (fault_count_o),
    .sequence_done_i (sequence_done_o),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one reference, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_ref(input logic [PAGE_BITS-1:0] pg, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    page     <= pg;
    last_ref <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold off the sender until every outstanding result has left
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [FcW-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid  <= 1'b0;
    frames_set  = value;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned          c;
    int unsigned          i;
    int unsigned          reach;
    logic [PAGE_BITS-1:0] pg;
    logic [PAGE_BITS-1:0] base;
    logic                 lst;
    logic                 fresh;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full stack at reset size, hits at front, middle and back, eviction
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h0005, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0002, 1'b0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'h0004, 1'b0);
    send_ref(16'h0006, 1'b0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'h0007, 1'b0);
    send_ref(16'hA5A5, 1'b1);
    // zero frames behaves as a single frame
    write_frames(4'd0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'h0003, 1'b0);
    send_ref(16'h5A5A, 1'b0);
    // oversize count saturates; writes clear frames but keep the fault total
    write_frames(4'd15);
    send_ref(16'h0009, 1'b0);
    send_ref(16'h0009, 1'b0);
    write_frames(4'd2);
    send_ref(16'h0009, 1'b0);
    send_ref(16'h000A, 1'b0);
    send_ref(16'h000B, 1'b0);
    send_ref(16'h0009, 1'b0);
    send_ref(16'h0009, 1'b1);

    // Random strings around a per-string base so that hits are common
    fresh = 1'b1;
    base  = '0;
    for (c = 0; c < CHUNKS; c++) begin
      if (c < 3) begin
        send_idle_pct  = 18;
        recv_stall_pct = 88;
      end else if (c < 6) begin
        send_idle_pct  = 88;
        recv_stall_pct = 18;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_frames(CHUNK_FRAMES[c]);
      reach = (frames_set == 0) ? 1 : (frames_set > MAX_FRAMES) ? MAX_FRAMES : 32'(frames_set);
      for (i = 0; i < CHUNK_REFS; i++) begin
        if ($urandom_range(199) == 0) drain();
        if (fresh) base = PAGE_BITS'($urandom_range(16'hFFFF));
        if ($urandom_range(9) == 0) begin
          pg = PAGE_BITS'($urandom_range(16'hFFFF));
        end else begin
          pg = base + PAGE_BITS'($urandom_range(reach + 2));
        end
        lst   = ($urandom_range(39) == 0);
        fresh = lst;
        send_ref(pg, lst);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_lru_page_replacement passed");
    end else begin
      $display("tb_lru_page_replacement failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(400000 * 12);
    $display("tb_lru_page_replacement failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lrup_pkg.sv
rtl/lrup_cell.sv
rtl/lru_page_replacement.sv
test/lrup_checker.sv
test/tb_lru_page_replacement.sv
